[hw/rtl/rpn_rule_stack_evaluator_assert.svh]
// assertion macros used by the evaluator port checker
`ifndef RPN_RULE_STACK_EVALUATOR_ASSERT_SVH
`define RPN_RULE_STACK_EVALUATOR_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define RPNSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define RPNSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/rpnse_pkg.sv]
// shared types, constants and helper functions of the rpn rule stack evaluator
package rpnse_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int NUM_REGS_DEF    = 10;
    localparam int DATA_W          = 32;
    localparam int CMD_W           = 5;
    localparam int RIDX_W          = 4;
    localparam int SLEEP_W         = 31;
    localparam int BOOL_REGS       = 10;
    localparam int S_TDATA_W       = 40;
    // top_value, write_valid, write_index, write_value, sleep_ms
    localparam int RES_FIXED_W     = DATA_W + 1 + RIDX_W + DATA_W + SLEEP_W;

    localparam logic [BOOL_REGS-1:0] BOOL_MASK_RST = 10'd231;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_LIT = 5'd0,
        CMD_PUSH_REF = 5'd1,
        CMD_ASSIGN   = 5'd2,
        CMD_SLEEP    = 5'd3,
        CMD_LAND     = 5'd4,
        CMD_LOR      = 5'd5,
        CMD_GE       = 5'd6,
        CMD_EQ       = 5'd7,
        CMD_LE       = 5'd8,
        CMD_NE       = 5'd9,
        CMD_AND      = 5'd10,
        CMD_OR       = 5'd11,
        CMD_XOR      = 5'd12,
        CMD_ADD      = 5'd13,
        CMD_SUB      = 5'd14,
        CMD_MUL      = 5'd15,
        CMD_DIV      = 5'd16,
        CMD_MOD      = 5'd17,
        CMD_LT       = 5'd18,
        CMD_GT       = 5'd19,
        CMD_NOT      = 5'd20,
        CMD_NOP      = 5'd21,
        CMD_EXT_SET  = 5'd22
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_DIVZ  = 2'd2,
        ST_OVER  = 2'd3
    } t_status;

    // binary operators other than divide and modulo, a is the popped top
    function automatic logic [DATA_W-1:0] alu(logic [CMD_W-1:0] op,
                                              logic [DATA_W-1:0] a,
                                              logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] r;
        r = '0;
        case (op)
            CMD_LAND: r = DATA_W'(a != '0 && b != '0);
            CMD_LOR:  r = DATA_W'(a != '0 || b != '0);
            CMD_GE:   r = DATA_W'($signed(a) >= $signed(b));
            CMD_EQ:   r = DATA_W'(a == b);
            CMD_LE:   r = DATA_W'($signed(a) <= $signed(b));
            CMD_NE:   r = DATA_W'(a != b);
            CMD_AND:  r = a & b;
            CMD_OR:   r = a | b;
            CMD_XOR:  r = a ^ b;
            CMD_ADD:  r = a + b;
            CMD_SUB:  r = a - b;
            CMD_MUL:  r = a * b;
            CMD_LT:   r = DATA_W'($signed(a) < $signed(b));
            CMD_GT:   r = DATA_W'($signed(a) > $signed(b));
            default:  r = '0;
        endcase
        return r;
    endfunction

    // boolean registers take 0 or 1 only
    function automatic logic [DATA_W-1:0] coerce(logic [BOOL_REGS-1:0] mask,
                                                 logic [DATA_W-1:0] idx,
                                                 logic [DATA_W-1:0] v);
        logic [15:0]       m16;
        logic [DATA_W-1:0] r;
        m16 = 16'(mask);
        r   = v;
        if (idx < DATA_W'(BOOL_REGS) && m16[idx[3:0]]) begin
            r = DATA_W'(v != '0);
        end
        return r;
    endfunction

endpackage

[hw/rtl/rpnse_sdiv.sv]
// bit-serial signed 32-bit divider, truncating quotient and remainder
module rpnse_sdiv (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rpnse_pkg::DATA_W-1:0] i_dividend,
    input  logic [rpnse_pkg::DATA_W-1:0] i_divisor,
    output logic                         o_done,
    output logic [rpnse_pkg::DATA_W-1:0] o_quot,
    output logic [rpnse_pkg::DATA_W-1:0] o_rem
);

    localparam int DW    = rpnse_pkg::DATA_W;
    localparam int CNT_W = $clog2(DW);

    logic             r_busy;
    logic             r_fix;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_quo;
    logic [DW-1:0]    r_dvs;
    logic             r_neg_q;
    logic             r_neg_r;
    logic [DW-1:0]    r_oq;
    logic [DW-1:0]    r_or;

    logic [DW:0]      trial;

    assign trial = {r_rem, r_quo[DW-1]} - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= '0;
                r_rem   <= '0;
                r_quo   <= i_dividend[DW-1] ? -i_dividend : i_dividend;
                r_dvs   <= i_divisor[DW-1] ? -i_divisor : i_divisor;
                r_neg_q <= i_dividend[DW-1] ^ i_divisor[DW-1];
                r_neg_r <= i_dividend[DW-1];
            end else if (r_busy) begin
                // restoring step: one quotient bit per cycle
                if (!trial[DW]) begin
                    r_rem <= trial[DW-1:0];
                end else begin
                    r_rem <= {r_rem[DW-2:0], r_quo[DW-1]};
                end
                r_quo <= {r_quo[DW-2:0], ~trial[DW]};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_fix  <= 1'b1;
                end
            end else if (r_fix) begin
                r_oq   <= r_neg_q ? -r_quo : r_quo;
                r_or   <= r_neg_r ? -r_rem : r_rem;
                r_fix  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_oq;
    assign o_rem  = r_or;

endmodule

[hw/rtl/rpn_rule_stack_evaluator.sv]
// top level of the rpn rule stack evaluator: sequencer, operand stack and io registers
//
//  channel   | dir | tdata (low bit up)                        | tuser
//  s_axis    | in  | literal_value[31:0], reg_index[35:32]     | command[4:0]
//  m_axis    | out | depth, top_value, write_valid,            | status[1:0]
//            |     | write_index, write_value, sleep_ms        |
//  i_cfg_*   | in  | bool_mask[9:0], written when i_cfg_wr_en  | -
//
//  one transaction at a time: accept, decode, operand read and resolve for pops, execute,
//  result push for ops that leave a value, top read and resolve (skipped when the stack
//  ends empty) and output register load; divide and modulo wait for the shared divider
//  that retires one quotient bit per cycle; the input reopens in the cycle after the load
//  reset clears the stack count and io register valid bits and loads bool_mask with 231
//  a result waits in the output register while the next transaction is accepted
module rpn_rule_stack_evaluator #(
    parameter int  STACK_DEPTH = rpnse_pkg::STACK_DEPTH_DEF,
    parameter int  NUM_REGS    = rpnse_pkg::NUM_REGS_DEF,
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1),
    localparam int M_TDATA_W   = ((DEPTH_W + rpnse_pkg::RES_FIXED_W + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write
    input  logic                            i_cfg_wr_en,
    input  logic [rpnse_pkg::BOOL_REGS-1:0] i_cfg_wr_data,   // bool_mask
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [rpnse_pkg::S_TDATA_W-1:0] s_axis_tdata,    // literal_value, reg_index
    input  logic [rpnse_pkg::CMD_W-1:0]     s_axis_tuser,    // command
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [M_TDATA_W-1:0]            m_axis_tdata,    // depth, top_value, write_valid,
                                                             // write_index, write_value, sleep_ms
    output logic [1:0]                      m_axis_tuser     // status
);

    localparam int DW = rpnse_pkg::DATA_W;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int IW = rpnse_pkg::RIDX_W;
    localparam int EW = DW + 1;    // stack entry: reference flag over value or index

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_RES_A,
        S_GET_A,
        S_GET_B,
        S_EXEC,
        S_DIV,
        S_PUSH,
        S_TOP,
        S_TOP_RES,
        S_TOP_GET,
        S_OUT
    } t_state;

    // sequencer and working registers
    t_state                          r_state;
    logic [rpnse_pkg::CMD_W-1:0]     r_cmd;
    logic [DW-1:0]                   r_lit;
    logic [IW-1:0]                   r_ridx;
    logic [DEPTH_W-1:0]              r_count;
    logic [EW-1:0]                   r_ent_a;
    logic [EW-1:0]                   r_ent_b;
    logic [DW-1:0]                   r_val_a;
    logic [DW-1:0]                   r_val_b;
    logic [DW-1:0]                   r_res;
    rpnse_pkg::t_status              r_st;
    logic                            r_wv;
    logic [IW-1:0]                   r_widx;
    logic [DW-1:0]                   r_wval;
    logic [rpnse_pkg::SLEEP_W-1:0]   r_sleep;
    logic [DW-1:0]                   r_top;
    logic [rpnse_pkg::BOOL_REGS-1:0] r_bool_mask;

    // output register
    logic                            r_m_vld;
    rpnse_pkg::t_status              r_o_st;
    logic [DEPTH_W-1:0]              r_o_depth;
    logic [DW-1:0]                   r_o_top;
    logic                            r_o_wv;
    logic [IW-1:0]                   r_o_widx;
    logic [DW-1:0]                   r_o_wval;
    logic [rpnse_pkg::SLEEP_W-1:0]   r_o_sleep;

    // operand stack and io register file
    logic [EW-1:0]                   r_stk_mem [STACK_DEPTH];
    logic [EW-1:0]                   r_stk_q;
    logic [DW-1:0]                   r_reg_mem [NUM_REGS];
    logic [NUM_REGS-1:0]             r_reg_vld;
    logic [DW-1:0]                   r_reg_q;
    logic                            r_reg_vq;

    logic                            stk_we;
    logic [AW-1:0]                   stk_waddr;
    logic [AW-1:0]                   stk_raddr;
    logic [EW-1:0]                   stk_wdata;
    logic [DEPTH_W-1:0]              cnt_m1;
    logic                            reg_we;
    logic [RW-1:0]                   reg_waddr;
    logic [RW-1:0]                   reg_raddr;
    logic [DW-1:0]                   reg_wdata;

    logic                            full;
    logic                            ridx_ok;
    logic                            two_pop;
    logic                            div_start;
    logic                            div_done;
    logic [DW-1:0]                   div_quot;
    logic [DW-1:0]                   div_rem;

    // a reference that names an existing register
    function automatic logic in_range(logic [EW-1:0] ent);
        return ent[DW] && (ent[DW-1:0] < DW'(NUM_REGS));
    endfunction

    // literal as is, reference through the register file, unwritten registers read zero
    function automatic logic [DW-1:0] resolve(logic [EW-1:0] ent, logic [DW-1:0] q,
                                              logic vq);
        logic [DW-1:0] v;
        if (!ent[DW]) begin
            v = ent[DW-1:0];
        end else if (in_range(ent) && vq) begin
            v = q;
        end else begin
            v = '0;
        end
        return v;
    endfunction

    assign full      = (r_count == DEPTH_W'(STACK_DEPTH));
    assign ridx_ok   = (DW'(r_ridx) < DW'(NUM_REGS));
    assign two_pop   = (r_cmd == rpnse_pkg::CMD_ASSIGN) ||
                       ((r_cmd >= rpnse_pkg::CMD_LAND) && (r_cmd <= rpnse_pkg::CMD_GT));
    assign cnt_m1    = r_count - DEPTH_W'(1);
    // the stack is always read just below the count: the top before and after each pop
    assign stk_raddr = cnt_m1[AW-1:0];
    assign stk_waddr = r_count[AW-1:0];
    // the register file is always read at the index in the entry just fetched
    assign reg_raddr = RW'(r_stk_q[DW-1:0]);

    assign div_start = (r_state == S_EXEC) && (r_val_b != '0) &&
                       ((r_cmd == rpnse_pkg::CMD_DIV) || (r_cmd == rpnse_pkg::CMD_MOD));

    // memory write control
    always_comb begin
        stk_we    = 1'b0;
        stk_wdata = {1'b0, r_res};
        reg_we    = 1'b0;
        reg_waddr = RW'(r_ent_a[DW-1:0]);
        reg_wdata = rpnse_pkg::coerce(r_bool_mask, r_ent_a[DW-1:0], r_val_b);
        case (r_state)
            S_DEC: begin
                if (!full && r_cmd == rpnse_pkg::CMD_PUSH_LIT) begin
                    stk_we    = 1'b1;
                    stk_wdata = {1'b0, r_lit};
                end
                if (!full && r_cmd == rpnse_pkg::CMD_PUSH_REF) begin
                    stk_we    = 1'b1;
                    stk_wdata = {1'b1, DW'(r_ridx)};
                end
                if (r_cmd == rpnse_pkg::CMD_EXT_SET) begin
                    reg_we    = ridx_ok;
                    reg_waddr = RW'(r_ridx);
                    reg_wdata = rpnse_pkg::coerce(r_bool_mask, DW'(r_ridx), r_lit);
                end
            end
            S_EXEC: begin
                // assign: target is entry a, source value is b
                reg_we = (r_cmd == rpnse_pkg::CMD_ASSIGN) && in_range(r_ent_a);
            end
            S_PUSH: begin
                stk_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[stk_waddr] <= stk_wdata;
        end
        r_stk_q <= r_stk_mem[stk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (reg_we) begin
            r_reg_mem[reg_waddr] <= reg_wdata;
        end
        r_reg_q  <= r_reg_mem[reg_raddr];
        r_reg_vq <= r_reg_vld[reg_raddr];
    end

    // io registers read as zero until written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_vld <= '0;
        end else if (reg_we) begin
            r_reg_vld[reg_waddr] <= 1'b1;
        end
    end

    rpnse_sdiv u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_val_a),
        .i_divisor  (r_val_b),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_m_vld     <= 1'b0;
            r_bool_mask <= rpnse_pkg::BOOL_MASK_RST;
        end else begin
            if (i_cfg_wr_en) begin
                r_bool_mask <= i_cfg_wr_data;
            end
            // the result register reloads in S_OUT, which sets the valid itself
            if (m_axis_tready && r_state != S_OUT) begin
                r_m_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd   <= s_axis_tuser;
                        r_lit   <= s_axis_tdata[DW-1:0];
                        r_ridx  <= s_axis_tdata[DW+IW-1:DW];
                        r_st    <= rpnse_pkg::ST_OK;
                        r_wv    <= 1'b0;
                        r_widx  <= '0;
                        r_wval  <= '0;
                        r_sleep <= '0;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_state <= S_TOP;
                    case (r_cmd) inside
                        rpnse_pkg::CMD_PUSH_LIT, rpnse_pkg::CMD_PUSH_REF: begin
                            if (full) begin
                                r_st <= rpnse_pkg::ST_OVER;
                            end else begin
                                r_count <= r_count + DEPTH_W'(1);
                            end
                        end
                        rpnse_pkg::CMD_ASSIGN, [rpnse_pkg::CMD_LAND:rpnse_pkg::CMD_GT]: begin
                            if (r_count < DEPTH_W'(2)) begin
                                // the single entry, if any, stays popped
                                r_st    <= rpnse_pkg::ST_UNDER;
                                r_count <= '0;
                            end else begin
                                r_count <= cnt_m1;
                                r_state <= S_RES_A;
                            end
                        end
                        rpnse_pkg::CMD_SLEEP, rpnse_pkg::CMD_NOT: begin
                            if (r_count == '0) begin
                                r_st <= rpnse_pkg::ST_UNDER;
                            end else begin
                                r_count <= cnt_m1;
                                r_state <= S_RES_A;
                            end
                        end
                        rpnse_pkg::CMD_EXT_SET: begin
                            if (ridx_ok) begin
                                r_wv   <= 1'b1;
                                r_widx <= r_ridx;
                                r_wval <= reg_wdata;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_RES_A: begin
                    // entry a arrived; the read of b is under way
                    r_ent_a <= r_stk_q;
                    if (two_pop) begin
                        r_count <= cnt_m1;
                    end
                    r_state <= S_GET_A;
                end
                S_GET_A: begin
                    r_val_a <= resolve(r_ent_a, r_reg_q, r_reg_vq);
                    r_ent_b <= r_stk_q;
                    r_state <= two_pop ? S_GET_B : S_EXEC;
                end
                S_GET_B: begin
                    r_val_b <= resolve(r_ent_b, r_reg_q, r_reg_vq);
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state <= S_PUSH;
                    case (r_cmd)
                        rpnse_pkg::CMD_ASSIGN: begin
                            if (in_range(r_ent_a)) begin
                                r_wv   <= 1'b1;
                                r_widx <= r_ent_a[IW-1:0];
                                r_wval <= reg_wdata;
                            end
                            r_state <= S_TOP;
                        end
                        rpnse_pkg::CMD_SLEEP: begin
                            // negative durations clamp to zero
                            r_sleep <= r_val_a[DW-1] ? '0 : r_val_a[rpnse_pkg::SLEEP_W-1:0];
                            r_state <= S_TOP;
                        end
                        rpnse_pkg::CMD_NOT: begin
                            r_res <= DW'(r_val_a == '0);
                        end
                        rpnse_pkg::CMD_DIV, rpnse_pkg::CMD_MOD: begin
                            if (r_val_b == '0) begin
                                r_st  <= rpnse_pkg::ST_DIVZ;
                                r_res <= '0;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                        default: begin
                            r_res <= rpnse_pkg::alu(r_cmd, r_val_a, r_val_b);
                        end
                    endcase
                end
                S_DIV: begin
                    if (div_done) begin
                        r_res   <= (r_cmd == rpnse_pkg::CMD_DIV) ? div_quot : div_rem;
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    r_count <= r_count + DEPTH_W'(1);
                    r_state <= S_TOP;
                end
                S_TOP: begin
                    // top entry read issued this cycle when the stack is not empty
                    if (r_count == '0) begin
                        r_top   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_TOP_RES;
                    end
                end
                S_TOP_RES: begin
                    r_ent_a <= r_stk_q;
                    r_state <= S_TOP_GET;
                end
                S_TOP_GET: begin
                    r_top   <= resolve(r_ent_a, r_reg_q, r_reg_vq);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_m_vld || m_axis_tready) begin
                        r_m_vld   <= 1'b1;
                        r_o_st    <= r_st;
                        r_o_depth <= r_count;
                        r_o_top   <= r_top;
                        r_o_wv    <= r_wv;
                        r_o_widx  <= r_widx;
                        r_o_wval  <= r_wval;
                        r_o_sleep <= r_sleep;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_vld;
    assign m_axis_tuser  = r_o_st;
    assign m_axis_tdata  = M_TDATA_W'({r_o_sleep, r_o_wval, r_o_widx, r_o_wv, r_o_top,
                                       r_o_depth});

endmodule

[hw/rtl/rpnse_chk.sv]
// port-level checker of the rpn rule stack evaluator and its bind
`include "rpn_rule_stack_evaluator_assert.svh"

module rpnse_chk #(
    parameter int  STACK_DEPTH = rpnse_pkg::STACK_DEPTH_DEF,
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1),
    localparam int M_TDATA_W   = ((DEPTH_W + rpnse_pkg::RES_FIXED_W + 7) / 8) * 8
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]           m_axis_tuser
);

    localparam int DW       = rpnse_pkg::DATA_W;
    localparam int OFS_TOP  = DEPTH_W;
    localparam int OFS_WV   = OFS_TOP + DW;
    localparam int OFS_WIDX = OFS_WV + 1;
    localparam int OFS_WVAL = OFS_WIDX + rpnse_pkg::RIDX_W;

    // one transaction in flight: the slave side closes right after an accept
    `RPNSE_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted while a transaction is in work")

    // depth never beyond the stack size
    `RPNSE_ASSERT_IMP(a_depth_bound, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[DEPTH_W-1:0] <= DEPTH_W'(STACK_DEPTH), "reported depth beyond stack size")

    // an empty stack shows a zero top
    `RPNSE_ASSERT_IMP(a_empty_top, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[DEPTH_W-1:0] == '0), m_axis_tdata[OFS_WV-1:OFS_TOP] == '0, "nonzero top on empty stack")

    // no register write means zero index and value
    `RPNSE_ASSERT_IMP(a_write_quiet, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[OFS_WV], (m_axis_tdata[OFS_WVAL-1:OFS_WIDX] == '0) && (m_axis_tdata[OFS_WVAL+DW-1:OFS_WVAL] == '0), "write fields set without a write")

    // a stalled result holds
    `RPNSE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind rpn_rule_stack_evaluator rpnse_chk #(
    .STACK_DEPTH (STACK_DEPTH)
) u_rpnse_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[tb/rpn_rule_stack_evaluator_checker.sv]
// result checker for the rpn rule stack evaluator: predicts each result and compares it
module rpn_rule_stack_evaluator_checker
    import rpnse_pkg::*;
#(
    parameter int M_W = 112
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [BOOL_REGS-1:0] i_cfg_wr_data,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,    // literal_value, reg_index
    input  logic [CMD_W-1:0]     i_s_tuser,    // command
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_W-1:0]       i_m_tdata,    // depth, top_value, write_valid,
                                               // write_index, write_value, sleep_ms
    input  logic [1:0]           i_m_tuser,    // status
    output int                   o_pending,
    output int                   o_errors
);

    localparam int STACK_SLOTS = STACK_DEPTH_DEF;
    localparam int IO_REGS     = NUM_REGS_DEF;

    typedef struct {
        t_status     status;
        logic [4:0]  depth;
        logic [31:0] top_value;
        logic        wr_valid;
        logic [3:0]  wr_index;
        logic [31:0] wr_value;
        logic [30:0] sleep_ms;
    } t_eval_result;

    // bit 32 marks a register reference
    logic [32:0]          op_stack [STACK_SLOTS];
    int                   op_count;
    logic [31:0]          io_regs [IO_REGS];
    logic [BOOL_REGS-1:0] bool_bits;
    t_eval_result         evals_due [$];
    t_eval_result         want;
    t_eval_result         got;

    function automatic logic [31:0] resolve_entry(logic [32:0] e);
        if (!e[32]) begin
            return e[31:0];
        end
        if (e[31:0] < IO_REGS) begin
            return io_regs[e[3:0]];
        end
        return '0;
    endfunction

    function automatic logic [31:0] as_register_value(logic [3:0] idx, logic [31:0] v);
        if (idx < BOOL_REGS && bool_bits[idx]) begin
            return {31'b0, v != '0};
        end
        return v;
    endfunction

    function automatic bit pop_entry(output logic [32:0] e);
        e = '0;
        if (op_count == 0) begin
            return 1'b0;
        end
        op_count--;
        e = op_stack[op_count];
        return 1'b1;
    endfunction

    function automatic bit push_entry(logic [32:0] e);
        if (op_count >= STACK_SLOTS) begin
            return 1'b0;
        end
        op_stack[op_count] = e;
        op_count++;
        return 1'b1;
    endfunction

    // a is the popped top, b the entry below it
    function automatic logic [31:0] combine(logic [CMD_W-1:0] op, logic [31:0] a,
                                            logic [31:0] b, output t_status st);
        logic signed [31:0] sa;
        logic signed [31:0] sb;
        longint             wide;
        sa   = a;
        sb   = b;
        st   = ST_OK;
        wide = 0;
        case (op)
            CMD_LAND: return {31'b0, a != '0 && b != '0};
            CMD_LOR:  return {31'b0, a != '0 || b != '0};
            CMD_GE:   return {31'b0, sa >= sb};
            CMD_EQ:   return {31'b0, a == b};
            CMD_LE:   return {31'b0, sa <= sb};
            CMD_NE:   return {31'b0, a != b};
            CMD_AND:  return a & b;
            CMD_OR:   return a | b;
            CMD_XOR:  return a ^ b;
            CMD_ADD:  return a + b;
            CMD_SUB:  return a - b;
            CMD_MUL:  return a * b;
            CMD_DIV, CMD_MOD: begin
                if (b == '0) begin
                    st = ST_DIVZ;
                    return '0;
                end
                // 64-bit signed so min / -1 wraps instead of trapping
                if (op == CMD_DIV) begin
                    wide = longint'(sa) / longint'(sb);
                end else begin
                    wide = longint'(sa) % longint'(sb);
                end
                return wide[31:0];
            end
            CMD_LT:   return {31'b0, sa < sb};
            default:  return {31'b0, sa > sb};
        endcase
    endfunction

    function automatic t_eval_result evaluate_item(logic [CMD_W-1:0] cmd, logic [31:0] lit,
                                                   logic [3:0] ridx);
        t_eval_result res;
        logic [32:0]  e1;
        logic [32:0]  e2;
        logic [31:0]  v;
        t_status      st;
        res.status   = ST_OK;
        res.wr_valid = 1'b0;
        res.wr_index = '0;
        res.wr_value = '0;
        res.sleep_ms = '0;
        if (cmd == CMD_PUSH_LIT) begin
            if (!push_entry({1'b0, lit})) res.status = ST_OVER;
        end else if (cmd == CMD_PUSH_REF) begin
            if (!push_entry({1'b1, 28'b0, ridx})) res.status = ST_OVER;
        end else if (cmd == CMD_ASSIGN) begin
            if (!pop_entry(e1) || !pop_entry(e2)) begin
                res.status = ST_UNDER;
            end else if (e1[32] && e1[31:0] < IO_REGS) begin
                v = as_register_value(e1[3:0], resolve_entry(e2));
                io_regs[e1[3:0]] = v;
                res.wr_valid = 1'b1;
                res.wr_index = e1[3:0];
                res.wr_value = v;
            end
        end else if (cmd == CMD_SLEEP) begin
            if (!pop_entry(e1)) begin
                res.status = ST_UNDER;
            end else begin
                v = resolve_entry(e1);
                res.sleep_ms = v[31] ? '0 : v[30:0];
            end
        end else if (cmd >= CMD_LAND && cmd <= CMD_GT) begin
            if (!pop_entry(e1) || !pop_entry(e2)) begin
                res.status = ST_UNDER;
            end else begin
                v = combine(cmd, resolve_entry(e1), resolve_entry(e2), st);
                void'(push_entry({1'b0, v}));
                res.status = st;
            end
        end else if (cmd == CMD_NOT) begin
            if (!pop_entry(e1)) begin
                res.status = ST_UNDER;
            end else begin
                void'(push_entry({32'b0, resolve_entry(e1) == '0}));
            end
        end else if (cmd == CMD_EXT_SET) begin
            if (ridx < IO_REGS) begin
                v = as_register_value(ridx, lit);
                io_regs[ridx] = v;
                res.wr_valid = 1'b1;
                res.wr_index = ridx;
                res.wr_value = v;
            end
        end
        res.depth     = 5'(op_count);
        res.top_value = (op_count != 0) ? resolve_entry(op_stack[op_count - 1]) : '0;
        return res;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected 0x%08h, actual 0x%08h", name, want_v, got_v);
            o_errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            op_count  = 0;
            bool_bits = BOOL_MASK_RST;
            foreach (io_regs[i]) io_regs[i] = '0;
            evals_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                bool_bits = i_cfg_wr_data;
            end
            if (i_m_tvalid && i_m_tready) begin
                got.status    = t_status'(i_m_tuser);
                got.depth     = i_m_tdata[4:0];
                got.top_value = i_m_tdata[36:5];
                got.wr_valid  = i_m_tdata[37];
                got.wr_index  = i_m_tdata[41:38];
                got.wr_value  = i_m_tdata[73:42];
                got.sleep_ms  = i_m_tdata[104:74];
                if (evals_due.size() == 0) begin
                    $error("result transaction with no item outstanding");
                    o_errors++;
                end else begin
                    want = evals_due[0];
                    evals_due.delete(0);
                    compare_field("status", 32'(want.status), 32'(got.status));
                    compare_field("depth", 32'(want.depth), 32'(got.depth));
                    compare_field("top_value", want.top_value, got.top_value);
                    compare_field("write_valid", 32'(want.wr_valid), 32'(got.wr_valid));
                    compare_field("write_index", 32'(want.wr_index), 32'(got.wr_index));
                    compare_field("write_value", want.wr_value, got.wr_value);
                    compare_field("sleep_ms", 32'(want.sleep_ms), 32'(got.sleep_ms));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                evals_due.push_back(evaluate_item(i_s_tuser, i_s_tdata[31:0],
                                                  i_s_tdata[35:32]));
            end
        end
        o_pending = evals_due.size();
    end

endmodule

[tb/tb_rpn_rule_stack_evaluator.sv]
// testbench top for the rpn rule stack evaluator: stimulus, handshake pressure and verdict
module tb_rpn_rule_stack_evaluator;
    import rpnse_pkg::*;

    localparam int RES_W = ((5 + RES_FIXED_W + 7) / 8) * 8;
    // highest command code, not decoded by the block
    localparam logic [CMD_W-1:0] CMD_UNUSED_LAST = 5'd31;
    localparam int ITEMS_TOTAL  = 600;
    // idle margin after the last result
    localparam int DRAIN_CYCLES = 60;
    // cycles without any transaction before the run is declared hung
    localparam int IDLE_LIMIT   = 4000;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_wr_en   = 1'b0;
    logic [BOOL_REGS-1:0] i_cfg_wr_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;     // literal_value, reg_index
    logic [CMD_W-1:0]     s_axis_tuser  = CMD_NOP; // command
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [RES_W-1:0]     m_axis_tdata;           // depth, top_value, write_valid,
                                                  // write_index, write_value, sleep_ms
    logic [1:0]           m_axis_tuser;           // status

    int pending;
    int failures;
    int items_sent  = 0;
    int burst_left  = 0;
    int idle_cycles = 0;
    int rx_window   = 0;
    int rx_mode     = 0;

    always #10 i_clk = ~i_clk;

    rpn_rule_stack_evaluator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    rpn_rule_stack_evaluator_checker #(
        .M_W (RES_W)
    ) evaluator_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .o_pending     (pending),
        .o_errors      (failures)
    );

    // result side: every window picks a stall mode, from always ready to long stalls
    always @(posedge i_clk) begin
        if (rx_window == 0) begin
            rx_mode   <= $urandom_range(0, 3);
            rx_window <= $urandom_range(20, 80);
        end else begin
            rx_window <= rx_window - 1;
        end
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= $urandom_range(0, 1);
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (rx_window[3:0] == 4'd0);
        endcase
    end

    // hang detection: any transaction on either channel restarts the count
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // one input transaction; the sender works in bursts with idle gaps between them
    task automatic send_item(logic [CMD_W-1:0] cmd, logic [31:0] lit = '0,
                             logic [3:0] ridx = '0);
        int gap;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, ridx, lit};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        items_sent++;
    endtask

    // mostly in-range registers, sometimes the unmapped ones that read as zero
    function automatic logic [3:0] pick_reg();
        if ($urandom_range(0, 7) == 0) begin
            return 4'($urandom_range(NUM_REGS_DEF, 15));
        end
        return 4'($urandom_range(0, NUM_REGS_DEF - 1));
    endfunction

    // literals biased toward zero, the signed extremes and small values
    function automatic logic [31:0] pick_literal();
        case ($urandom_range(0, 6))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'($urandom_range(0, 20));
            5:       return -32'($urandom_range(1, 20));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_binop();
        return CMD_W'(CMD_LAND + $urandom_range(0, CMD_GT - CMD_LAND));
    endfunction

    // literal or register reference, the unused field filled with noise
    task automatic push_operand();
        if ($urandom_range(0, 2) == 0) begin
            send_item(CMD_PUSH_REF, $urandom, pick_reg());
        end else begin
            send_item(CMD_PUSH_LIT, pick_literal(), 4'($urandom_range(0, 15)));
        end
    endtask

    // random rule fragments until the item count reaches upto
    task automatic run_rules(int upto);
        int         kind;
        int         n;
        logic [3:0] r;
        while (items_sent < upto) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                // binary op, usually on fresh operands, sometimes on older stack entries
                n = $urandom_range(0, 3);
                if (n == 3) n = 2;
                repeat (n) push_operand();
                send_item(pick_binop());
            end else if (kind < 50) begin
                push_operand();
                send_item($urandom_range(0, 1) ? CMD_NOT : CMD_SLEEP);
            end else if (kind < 62) begin
                // assign: source below, target on top, now and then a literal target
                push_operand();
                if ($urandom_range(0, 4) == 0) begin
                    push_operand();
                end else begin
                    send_item(CMD_PUSH_REF, $urandom, pick_reg());
                end
                send_item(CMD_ASSIGN);
            end else if (kind < 70) begin
                // a reference resolves when popped, so change the register in between
                r = pick_reg();
                send_item(CMD_PUSH_REF, $urandom, r);
                send_item(CMD_EXT_SET, pick_literal(), r);
                push_operand();
                send_item(pick_binop());
            end else if (kind < 77) begin
                send_item(CMD_EXT_SET, pick_literal(), 4'($urandom_range(0, 15)));
            end else if (kind < 80) begin
                // fill past the top of the stack, then fold part of it back
                repeat (STACK_DEPTH_DEF + 1) push_operand();
                repeat (12) send_item(pick_binop());
            end else if (kind < 90) begin
                // drain, running into underflow when the stack is shallow
                repeat ($urandom_range(1, 6)) send_item(CMD_SLEEP, $urandom,
                                                        4'($urandom_range(0, 15)));
            end else begin
                // raw noise over the whole command space, unused codes included
                repeat ($urandom_range(1, 3)) send_item(CMD_W'($urandom_range(0, 31)),
                                                        $urandom,
                                                        4'($urandom_range(0, 15)));
            end
        end
    endtask

    // hold the sender off until every outstanding result has come back
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // the mask only changes while the block has nothing in flight
    task automatic load_bool_mask(logic [BOOL_REGS-1:0] mask);
        wait_results_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mask;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // operators on an empty stack
        send_item(CMD_ADD);
        send_item(CMD_SLEEP);
        // external sets: boolean register, plain register, unmapped register
        send_item(CMD_EXT_SET, 32'd5, 4'd0);
        send_item(CMD_EXT_SET, 32'hFFFF_FFF9, 4'd3);
        send_item(CMD_EXT_SET, 32'd1, 4'd12);
        // divide by zero, then most negative over minus one
        send_item(CMD_PUSH_LIT, 32'd0);
        send_item(CMD_PUSH_LIT, 32'd100);
        send_item(CMD_DIV);
        send_item(CMD_PUSH_LIT, 32'hFFFF_FFFF);
        send_item(CMD_PUSH_LIT, 32'h8000_0000);
        send_item(CMD_DIV);
        // assign to an unmapped register writes nothing
        send_item(CMD_PUSH_LIT, 32'd9);
        send_item(CMD_PUSH_REF, 32'd0, 4'd12);
        send_item(CMD_ASSIGN);
        // assign to a literal target only pops
        send_item(CMD_PUSH_LIT, 32'd42);
        send_item(CMD_PUSH_LIT, 32'd7);
        send_item(CMD_ASSIGN);
        // negative value into a boolean register is coerced to one
        send_item(CMD_PUSH_REF, 32'd0, 4'd3);
        send_item(CMD_PUSH_REF, 32'd0, 4'd1);
        send_item(CMD_ASSIGN);
        // negative sleep clamps to zero
        send_item(CMD_PUSH_LIT, 32'hFFFF_FFFB);
        send_item(CMD_SLEEP);
        send_item(CMD_NOT);
        send_item(CMD_NOP);
        send_item(CMD_UNUSED_LAST);

        // random phases under the mask extremes and one random mask
        load_bool_mask('0);
        run_rules(220);
        load_bool_mask('1);
        run_rules(420);
        load_bool_mask(BOOL_REGS'($urandom));
        run_rules(ITEMS_TOTAL);

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[rpn_rule_stack_evaluator.f]
+incdir+hw/rtl
hw/rtl/rpnse_pkg.sv
hw/rtl/rpnse_sdiv.sv
hw/rtl/rpn_rule_stack_evaluator.sv
hw/rtl/rpnse_chk.sv
tb/rpn_rule_stack_evaluator_checker.sv
tb/tb_rpn_rule_stack_evaluator.sv
